// ===== rtl/core/mstp_pkg.sv =====
`default_nettype none

package mstp_pkg;

	localparam int SLOT_COUNT_DEF = 32;
	localparam int TIME_BITS      = 48;
	localparam int TAG_BITS       = 16;
	localparam int DELAY_BITS     = 32;
	localparam int CMD_BITS       = 3;
	localparam int KIND_BITS      = 2;

	// Width of the deadline sum before saturation.
	localparam int SUM_W = ((TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS) + 1;

	localparam logic [CMD_BITS-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_REPEAT  = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE  = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_QUERY   = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_PROCESS = 3'd4;

	localparam logic [KIND_BITS-1:0] KIND_DONE  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_FIRED = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_WAIT  = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]   command;
		logic [DELAY_BITS-1:0] delay_ticks;
		logic [TAG_BITS-1:0]   handler_id;
		logic [TAG_BITS-1:0]   context_id;
		logic [TIME_BITS-1:0]  now_ticks;
		logic [TIME_BITS-1:0]  wait_limit_ticks;
	} item_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] result_kind;
		logic                 success;
		logic [TAG_BITS-1:0]  fired_handler;
		logic [TAG_BITS-1:0]  fired_context;
		logic [TIME_BITS-1:0] fired_deadline;
		logic [TIME_BITS-1:0] wait_ticks;
		logic                 last_of_run;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic calc;
		logic report;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic is_process;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC,
		ST_REPORT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mstp_ctrl.sv =====
`default_nettype none

module mstp_ctrl import mstp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output ctl_t      ctl,
	input  wire sts_t sts
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctl.step = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// The last slot is being evaluated in the datapath stage.
				state_nxt = sts.is_process ? ST_CALC : ST_REPORT;
			end
			ST_CALC: begin
				ctl.calc  = 1'b1;
				state_nxt = ST_REPORT;
			end
			ST_REPORT: begin
				ctl.report = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/mstp_dp.sv =====
`default_nettype none

module mstp_dp import mstp_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire ctl_t  ctl,
	output sts_t       sts,
	output logic       strobe,
	output result_t    result
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [TAG_BITS-1:0]  handler;
		logic [TAG_BITS-1:0]  context_tag;
	} slot_t;

	slot_t mem [SLOT_COUNT];

	item_t                item_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic                 ok_q;
	logic                 any_q;
	logic [TIME_BITS-1:0] min_q;
	logic [TIME_BITS-1:0] diff_q;
	logic [TIME_BITS-1:0] lf_deadline_q;
	logic                 lf_valid_q;

	slot_t                rd_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;

	logic                 strobe_q;
	result_t              result_q;

	logic                 is_add;
	logic                 slot_act;
	logic                 tag_hit;
	logic                 expired;
	logic                 place;
	logic                 drop;
	logic                 fire;
	logic [TIME_BITS-1:0] base;
	logic [SUM_W-1:0]     sum_w;
	logic [TIME_BITS-1:0] new_deadline;
	logic [TIME_BITS-1:0] wait_val;
	result_t              res_nxt;

	assign is_add   = (item_q.command == CMD_ADD) || (item_q.command == CMD_REPEAT);
	assign slot_act = vld_s1 && active_q[idx_s1];
	assign tag_hit  = slot_act && (rd_s1.handler == item_q.handler_id)
	                  && (rd_s1.context_tag == item_q.context_id);
	assign expired  = slot_act && (rd_s1.deadline <= item_q.now_ticks);
	assign place    = is_add && vld_s1 && !active_q[idx_s1] && !ok_q;
	assign drop     = (item_q.command == CMD_REMOVE) && tag_hit;
	assign fire     = (item_q.command == CMD_PROCESS) && expired;

	assign sts.scan_last  = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign sts.is_process = (item_q.command == CMD_PROCESS);

	// Repeat measures from the last fired deadline once anything has fired.
	assign base  = ((item_q.command == CMD_REPEAT) && lf_valid_q) ? lf_deadline_q
	               : item_q.now_ticks;
	assign sum_w = SUM_W'(base) + SUM_W'(item_q.delay_ticks);
	assign new_deadline = (|sum_w[SUM_W-1:TIME_BITS]) ? '1 : sum_w[TIME_BITS-1:0];

	assign wait_val = !any_q ? item_q.wait_limit_ticks
	                  : ((diff_q > item_q.wait_limit_ticks) ? item_q.wait_limit_ticks
	                     : diff_q);

	always_comb begin
		res_nxt = '0;
		if (ctl.report) begin
			res_nxt.last_of_run = 1'b1;
			if (sts.is_process) begin
				res_nxt.result_kind = KIND_WAIT;
				res_nxt.wait_ticks  = wait_val;
			end else begin
				res_nxt.result_kind = KIND_DONE;
				res_nxt.success     = ok_q;
			end
		end else begin
			res_nxt.result_kind    = KIND_FIRED;
			res_nxt.fired_handler  = rd_s1.handler;
			res_nxt.fired_context  = rd_s1.context_tag;
			res_nxt.fired_deadline = rd_s1.deadline;
		end
	end

	always_ff @(posedge clk) begin
		if (place) begin
			mem[idx_s1] <= '{deadline: new_deadline, handler: item_q.handler_id,
			                 context_tag: item_q.context_id};
		end
		if (ctl.step) begin
			rd_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (ctl.load) begin
			item_q <= item;
		end
		if (slot_act && !expired && (!any_q || rd_s1.deadline < min_q)) begin
			min_q <= rd_s1.deadline;
		end
		if (ctl.calc) begin
			diff_q <= (min_q > item_q.now_ticks) ? min_q - item_q.now_ticks : '0;
		end
		if (fire || ctl.report) begin
			result_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			active_q      <= '0;
			ok_q          <= 1'b0;
			any_q         <= 1'b0;
			lf_deadline_q <= '0;
			lf_valid_q    <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			vld_s1   <= ctl.step;
			strobe_q <= fire || ctl.report;
			if (ctl.load) begin
				idx_q <= '0;
				ok_q  <= 1'b0;
				any_q <= 1'b0;
			end else if (ctl.step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (place) begin
				active_q[idx_s1] <= 1'b1;
				ok_q             <= 1'b1;
			end
			if ((item_q.command == CMD_QUERY) && tag_hit) begin
				ok_q <= 1'b1;
			end
			if (drop || fire) begin
				active_q[idx_s1] <= 1'b0;
			end
			if (fire) begin
				lf_deadline_q <= rd_s1.deadline;
				lf_valid_q    <= 1'b1;
			end
			if ((item_q.command == CMD_PROCESS) && slot_act && !expired) begin
				any_q <= 1'b1;
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/multi_slot_timeout_pool.sv =====
// Channel     | Ports                       | Transaction taken when
// ------------+-----------------------------+--------------------------------------
// command in  | start, busy, item (item_t)  | rising edge with start high, busy low
// result out  | strobe, result (result_t)   | rising edge ending the strobe cycle
//
// A command scans every slot, one slot per cycle, through a single slot
// memory read port; busy stays high through the scan, a drain step, a
// subtract step for process only, and the report step.
// Fired timeouts appear as the slots are scanned; the final result follows them.
// Reset clears the slot active marks and the fired-deadline record at once;
// no clearing pass is needed. The receiver cannot stall: every result is
// shown for exactly one cycle.
`default_nettype none

module multi_slot_timeout_pool import mstp_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       strobe,
	output result_t    result
);

	// Control and status between the sequencer and the slot datapath.
	ctl_t ctl;
	sts_t sts;

	// The controller walks IDLE, SCAN, DRAIN, an optional CALC for process,
	// and REPORT. The datapath owns the slot memory, the active marks and the
	// result register.
	mstp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.sts    (sts)
	);

	mstp_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.strobe (strobe),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== rtl/core/mstp_chk.sv =====
`default_nettype none

module mstp_chk import mstp_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    strobe,
	input wire result_t result
);

	// A taken transaction makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after a transaction");

	// Leaving busy always coincides with the closing result.
	a_fall_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last_of_run)
		else $error("busy fell without a final result");

	// Intermediate results only appear while a command is in progress.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_run |-> busy)
		else $error("intermediate result while idle");

	// A fired timeout never closes a run and never carries success.
	a_fired_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.result_kind == KIND_FIRED) |->
			!result.last_of_run && !result.success)
		else $error("malformed fired result");

	// Only a fired timeout may be followed by more results of the same run.
	a_mid_kind: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_run |-> result.result_kind == KIND_FIRED)
		else $error("non-final result of the wrong kind");

endmodule

bind multi_slot_timeout_pool mstp_chk u_chk (.*);

`default_nettype wire
